### rtl/stpi_pkg.sv
// Shared types and constants for the sorted table with place insertion.
`default_nettype none
package stpi_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned TAG_BITS   = 16;
  localparam int unsigned INDEX_BITS = 6;
  localparam int unsigned SLOT_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Width that holds both an index and any slot number, plus DEPTH itself.
  localparam int unsigned CMP_BITS   =
      ((SLOT_BITS > INDEX_BITS) ? SLOT_BITS : INDEX_BITS) + 1;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic                       op;
    logic [INDEX_BITS-1:0]      index;
    logic signed [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0]        tag;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] key_out;
    logic [TAG_BITS-1:0]        tag_out;
    logic [INDEX_BITS-1:0]      slot;
    logic signed [KEY_BITS-1:0] head_key;
    logic signed [KEY_BITS-1:0] tail_key;
  } out_item_t;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0]        tag;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                       cmp;
    logic                       upd;
    logic [INDEX_BITS-1:0]      index;
    logic signed [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0]        tag;
  } cell_ctrl_t;

endpackage : stpi_pkg
`default_nettype wire

### rtl/sorted_table_place_insert.sv
// Top level of the sorted table: a chain of slot cells with a small controller.
`default_nettype none
// Usage:
//   Input channel in_valid_i / in_stall_o / in_data_i carries one transaction per
//   item: op selects place (sorted insertion) or read, with index, key and tag.
//   Output channel out_valid_o / out_stall_i / out_data_o returns one result per
//   item: key and tag placed or read, the slot, and the head and tail keys
//   after the step.
//   A transaction is taken when valid is high and stall is low at a clock edge.
// Operation:
//   Each item passes through accept, compare (every cell checks its key
//   against the new key in parallel), shift/write (cells pass entries to their
//   right neighbor), and load of the output register. in_stall_o is high from
//   acceptance until the result is loaded, so no new item is accepted until the
//   previous one has passed the compare-then-shift sequence of the chain.
//   A finished result sits in the output register while the next item is
//   accepted and processed; if the receiver still stalls when that next result
//   is ready, the controller holds it and keeps in_stall_o high.
// Reset:
//   rst_ni clears every slot to key zero and tag zero, empties the output
//   register and returns the controller to idle. No clearing pass is needed.
module sorted_table_place_insert
  import stpi_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output      logic      in_stall_o,
  input  wire in_item_t  in_data_i,
  output      logic      out_valid_o,
  input  wire logic      out_stall_i,
  output      out_item_t out_data_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SHIFT,
    S_PUSH
  } state_e;

  state_e     state_q;
  in_item_t   req_q;
  logic [INDEX_BITS-1:0] slot_q;
  logic       out_valid_q;
  out_item_t  out_q;

  cell_ctrl_t ctrl;
  entry_t     entries [DEPTH];
  logic       found   [DEPTH+1];
  logic       take    [DEPTH];

  logic       in_acc, out_acc, push;
  logic       idx_in_range;
  logic [INDEX_BITS-1:0] slot_enc;
  entry_t     rd_entry;
  out_item_t  out_new;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign push       = (state_q == S_PUSH) && (!out_valid_q || !out_stall_i);

  // Broadcast the held request; compare in S_CMP, shift in S_SHIFT right after it.
  always_comb begin
    ctrl.cmp   = (state_q == S_CMP);
    ctrl.upd   = (state_q == S_SHIFT) && (req_q.op == OP_PLACE);
    ctrl.index = req_q.index;
    ctrl.key   = req_q.key;
    ctrl.tag   = req_q.tag;
  end

  assign found[0] = 1'b0;

  for (genvar p = 0; p < DEPTH; p++) begin : g_cell
    entry_t prev;
    if (p == 0) begin : g_first
      assign prev = '0;
    end else begin : g_rest
      assign prev = entries[p-1];
    end
    stpi_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .pos_i        (SLOT_BITS'(p)),
      .prev_entry_i (prev),
      .found_i      (found[p]),
      .found_o      (found[p+1]),
      .take_o       (take[p]),
      .entry_o      (entries[p])
    );
  end

  // Encode the landing slot; fall back to the index when no cell takes it.
  always_comb begin
    slot_enc = req_q.index;
    for (int p = 0; p < DEPTH; p++) begin
      if (take[p]) begin
        slot_enc = INDEX_BITS'(p);
      end
    end
  end

  assign idx_in_range = CMP_BITS'(req_q.index) < CMP_BITS'(DEPTH);

  always_comb begin
    rd_entry = '0;
    if (idx_in_range) begin
      rd_entry = entries[req_q.index[SLOT_BITS-1:0]];
    end
  end

  always_comb begin
    out_new.slot     = slot_q;
    out_new.head_key = entries[0].key;
    out_new.tail_key = entries[DEPTH-1].key;
    if (req_q.op == OP_PLACE) begin
      out_new.key_out = req_q.key;
      out_new.tag_out = req_q.tag;
    end else begin
      out_new.key_out = rd_entry.key;
      out_new.tag_out = rd_entry.tag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_CMP;
          end
        end
        S_CMP:   state_q <= S_SHIFT;
        S_SHIFT: state_q <= S_PUSH;
        S_PUSH: begin
          if (push) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      // Hold the result until taken; a fresh push replaces a taken one.
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
    if (state_q == S_SHIFT) begin
      slot_q <= (req_q.op == OP_PLACE) ? slot_enc : req_q.index;
    end
    if (push) begin
      out_q <= out_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : sorted_table_place_insert
`default_nettype wire

### rtl/stpi_cell.sv
// One table slot: holds an entry, compares it against the new key, shifts from its left neighbor.
`default_nettype none
module stpi_cell
  import stpi_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cell_ctrl_t           ctrl_i,
  input  wire logic [SLOT_BITS-1:0] pos_i,
  input  wire entry_t               prev_entry_i,
  input  wire logic                 found_i,
  output      logic                 found_o,
  output      logic                 take_o,
  output      entry_t               entry_o
);

  entry_t entry_q, entry_d;
  logic   gt_q, gt_d;
  logic   below_idx, at_idx, upto_idx;

  assign below_idx = CMP_BITS'(pos_i) <  CMP_BITS'(ctrl_i.index);
  assign at_idx    = CMP_BITS'(pos_i) == CMP_BITS'(ctrl_i.index);
  assign upto_idx  = below_idx | at_idx;

  // First strictly greater slot below the index, or the index itself.
  assign found_o = found_i | gt_q;
  assign take_o  = !found_i && (gt_q || at_idx);

  always_comb begin
    gt_d    = gt_q;
    entry_d = entry_q;
    if (ctrl_i.cmp) begin
      gt_d = below_idx && (entry_q.key > ctrl_i.key);
    end
    if (ctrl_i.upd) begin
      if (take_o) begin
        entry_d.key = ctrl_i.key;
        entry_d.tag = ctrl_i.tag;
      end else if (found_i && upto_idx) begin
        entry_d = prev_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
      gt_q    <= 1'b0;
    end else begin
      entry_q <= entry_d;
      gt_q    <= gt_d;
    end
  end

  assign entry_o = entry_q;

endmodule : stpi_cell
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for the sorted table with place insertion.
`default_nettype none
module testbench
  import stpi_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Track the table contents and the results owed by the block, in order of
  // acceptance. Every accepted transaction owes exactly one result.
  class sorted_table_tracker;
    logic signed [KEY_BITS-1:0] keys [DEPTH];
    logic [TAG_BITS-1:0]        tags [DEPTH];
    out_item_t                  replies_due [$];
    int unsigned                errors;

    function new();
      foreach (keys[i]) begin
        keys[i] = '0;
        tags[i] = '0;
      end
      errors = 0;
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    // Apply one accepted transaction to the tracked table and queue its result.
    function void take_request(in_item_t req);
      out_item_t                  reply;
      logic signed [KEY_BITS-1:0] new_key;
      int unsigned                pos;
      int unsigned                p;
      new_key       = req.key;
      reply.key_out = '0;
      reply.tag_out = '0;
      reply.slot    = req.index;
      if (req.op == OP_PLACE) begin
        reply.key_out = req.key;
        reply.tag_out = req.tag;
        if (req.index < DEPTH) begin
          // First slot below the start slot holding a strictly greater key.
          pos = req.index;
          for (p = 0; p < req.index; p++) begin
            if (keys[p] > new_key) begin
              pos = p;
              break;
            end
          end
          for (p = req.index; p > pos; p--) begin
            keys[p] = keys[p-1];
            tags[p] = tags[p-1];
          end
          keys[pos]  = new_key;
          tags[pos]  = req.tag;
          reply.slot = pos[INDEX_BITS-1:0];
        end
      end else if (req.index < DEPTH) begin
        reply.key_out = keys[req.index];
        reply.tag_out = tags[req.index];
      end
      reply.head_key = keys[0];
      reply.tail_key = keys[DEPTH-1];
      replies_due.push_back(reply);
    endfunction

    function void compare_field(string fname, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest owed result.
    function void check_reply(out_item_t got);
      out_item_t want;
      if (replies_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, expected none, actual key 0x%0h slot %0d",
                 $time, got.key_out, got.slot);
        return;
      end
      want = replies_due.pop_front();
      compare_field("key_out",  want.key_out,  got.key_out);
      compare_field("tag_out",  want.tag_out,  got.tag_out);
      compare_field("slot",     want.slot,     got.slot);
      compare_field("head_key", want.head_key, got.head_key);
      compare_field("tail_key", want.tail_key, got.tail_key);
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  sorted_table_tracker tracker;

  // Set by the stimulus: quiet drops all idling on both sides, hold_request
  // asks the receiver for one long stall.
  bit quiet;
  bit hold_request;

  // Fill pointer for runs of placements at rising start slots.
  int unsigned fill_ptr;

  sorted_table_place_insert uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watch both channels at every rising edge. Values read here are the ones
  // from before the edge, since all updates land in the nonblocking region.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) tracker.check_reply(out_data_o);
      if (in_valid_i && !in_stall_o) tracker.take_request(in_data_i);
    end
  end

  // Receiver: stall a random number of cycles before each result, unless quiet.
  // On request, hold off for a long stretch so the block backs up and stalls
  // its input while the sender keeps offering transactions.
  initial begin
    int unsigned n;
    out_stall_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 5);
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      // Advance until one result transaction completes.
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Hard limit on the run; the slowest correct run needs well under a tenth.
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic in_item_t make_request(logic op, int unsigned index,
                                            logic [KEY_BITS-1:0] key,
                                            logic [TAG_BITS-1:0] tag);
    in_item_t req;
    req.op    = op;
    req.index = index[INDEX_BITS-1:0];
    req.key   = key;
    req.tag   = tag;
    return req;
  endfunction

  // Draw a key: full range, a narrow band around zero to force ties, or an
  // extreme value.
  function automatic logic [KEY_BITS-1:0] draw_key();
    logic [KEY_BITS-1:0] k;
    case ($urandom_range(0, 3))
      0, 3: k = $urandom;
      1: k = $urandom_range(0, 6) - 3;
      default: begin
        case ($urandom_range(0, 3))
          0: k = {1'b1, {(KEY_BITS-1){1'b0}}};
          1: k = {1'b0, {(KEY_BITS-1){1'b1}}};
          2: k = '1;
          default: k = '0;
        endcase
      end
    endcase
    return k;
  endfunction

  // Offer one transaction after a random gap; hold it until accepted. Valid
  // is only lowered when a gap follows, so back-to-back transactions keep it
  // high with a single assignment per time step.
  task automatic send_request(in_item_t req);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Pause the sender until every owed result has come back.
  task automatic wait_for_replies();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // Random traffic shaped like the optimizer around the table: mostly new
  // points dropped in at the worst slot, runs that fill the table from the
  // bottom, some placements at random start slots, and reads anywhere.
  task automatic run_segment(int unsigned count);
    int unsigned r;
    in_item_t    req;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        req = make_request(OP_PLACE, DEPTH - 1, draw_key(), TAG_BITS'($urandom));
      end else if (r < 60) begin
        req = make_request(OP_PLACE, fill_ptr, draw_key(), TAG_BITS'($urandom));
        fill_ptr = (fill_ptr + 1) % DEPTH;
      end else if (r < 75) begin
        req = make_request(OP_PLACE, $urandom_range(0, DEPTH - 1), draw_key(),
                           TAG_BITS'($urandom));
      end else begin
        // Random key and tag bits on reads too; the block must ignore them.
        req = make_request(OP_READ, $urandom_range(0, DEPTH - 1), $urandom,
                           TAG_BITS'($urandom));
      end
      send_request(req);
    end
  endtask

  initial begin
    tracker      = new();
    quiet        = 1'b0;
    hold_request = 1'b0;
    fill_ptr     = 0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: read the cleared table at both ends, place the extreme
    // keys at the extreme start slots, then ties and small keys.
    send_request(make_request(OP_READ,  0,  '1, '1));
    send_request(make_request(OP_READ,  63, '0, '0));
    send_request(make_request(OP_PLACE, 0,  32'h7fff_ffff, 16'hffff));
    send_request(make_request(OP_PLACE, 63, 32'h8000_0000, 16'h0000));
    send_request(make_request(OP_READ,  0,  '0, '0));
    send_request(make_request(OP_READ,  1,  '0, '0));
    send_request(make_request(OP_READ,  63, '0, '0));
    // Equal keys must keep arrival order.
    send_request(make_request(OP_PLACE, 10, 32'h0000_0000, 16'h0a0a));
    send_request(make_request(OP_PLACE, 10, 32'h0000_0000, 16'h0b0b));
    send_request(make_request(OP_PLACE, 5,  32'hffff_ffff, 16'h5555));
    send_request(make_request(OP_PLACE, 5,  32'h0000_0001, 16'haaaa));
    // Key greater than every slot below the start slot: no shift at all.
    send_request(make_request(OP_PLACE, 3,  32'h7fff_ffff, 16'h1234));
    send_request(make_request(OP_PLACE, 1,  32'h8000_0000, 16'h8001));
    send_request(make_request(OP_PLACE, 63, 32'h7fff_ffff, 16'hfffe));
    send_request(make_request(OP_READ,  2,  '0, '0));
    send_request(make_request(OP_READ,  3,  '0, '0));
    send_request(make_request(OP_READ,  62, '0, '0));
    send_request(make_request(OP_READ,  63, '1, '1));
    wait_for_replies();

    // Random part: alternate idling and quiet stretches, one long receiver
    // hold with the sender pushing back to back, and one full drain midway.
    for (int seg = 0; seg < 18; seg++) begin
      quiet = (seg % 4 == 1);
      if (seg == 4) begin
        quiet        = 1'b1;
        hold_request = 1'b1;
      end
      if (seg == 9) wait_for_replies();
      run_segment(100);
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    // Give stray results a chance to show up.
    repeat (20) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule : testbench
`default_nettype wire
